@@ rtl/notch_pkg.sv @@
// Shared types and constants for the biquad notch filter.
// Used by notch_calc and iir_notch_biquad; depends on nothing else.
package notch_pkg;

	// Default values for the top-level parameters.
	localparam int FRACTION_BITS_DEF = 8;
	localparam int SAMPLE_WIDTH_DEF  = 16;

	// Coefficient and output widths are fixed by the register map.
	localparam int COEFF_W = 12;
	localparam int OUT_W   = 24;
	localparam int INDEX_W = 3;

	// Configuration register indexes.
	typedef enum logic [INDEX_W-1:0] {
		REG_FF_COEFF_0 = 3'd0,
		REG_FF_COEFF_1 = 3'd1,
		REG_FF_COEFF_2 = 3'd2,
		REG_FB_COEFF_1 = 3'd3,
		REG_FB_COEFF_2 = 3'd4
	} reg_index_t;

	// The five filter weights, scaled by 2^FRACTION_BITS.
	typedef struct packed {
		logic signed [COEFF_W-1:0] ff0;
		logic signed [COEFF_W-1:0] ff1;
		logic signed [COEFF_W-1:0] ff2;
		logic signed [COEFF_W-1:0] fb1;
		logic signed [COEFF_W-1:0] fb2;
	} coeff_set_t;

	// Reset weights: a 60 Hz notch at a 1 kHz sample rate.
	localparam coeff_set_t COEFF_RESET = '{
		ff0: 12'sd256,
		ff1: -12'sd476,
		ff2: 12'sd256,
		fb1: 12'sd471,
		fb2: -12'sd251
	};

endpackage

@@ rtl/notch_calc.sv @@
// Combinational biquad datapath: five products, one sum, rounding, saturation.
// Depends on notch_pkg for the coefficient set type and the output width.
module notch_calc #(
	parameter int FRACTION_BITS = notch_pkg::FRACTION_BITS_DEF,
	parameter int SAMPLE_WIDTH  = notch_pkg::SAMPLE_WIDTH_DEF
) (
	input  notch_pkg::coeff_set_t                coeffs,
	input  logic signed [SAMPLE_WIDTH-1:0]       x0,
	input  logic signed [SAMPLE_WIDTH-1:0]       x1,
	input  logic signed [SAMPLE_WIDTH-1:0]       x2,
	input  logic signed [notch_pkg::OUT_W-1:0]   y1,
	input  logic signed [notch_pkg::OUT_W-1:0]   y2,
	output logic signed [notch_pkg::OUT_W-1:0]   y
);
	import notch_pkg::*;

	localparam int PW_X  = COEFF_W + SAMPLE_WIDTH;
	localparam int PW_Y  = COEFF_W + OUT_W;
	localparam int PW    = (PW_X > PW_Y) ? PW_X : PW_Y;
	// Five products plus the rounding bias need three guard bits.
	localparam int ACC_W = PW + 3;

	localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(1) <<< (FRACTION_BITS - 1);
	localparam logic signed [ACC_W-1:0] TRUNC_ADJ  =
		(ACC_W'(1) <<< FRACTION_BITS) - ACC_W'(1);
	localparam logic signed [ACC_W-1:0] OUT_MAX_A  = (ACC_W'(1) <<< (OUT_W - 1)) - ACC_W'(1);
	localparam logic signed [ACC_W-1:0] OUT_MIN_A  = -OUT_MAX_A - ACC_W'(1);

	logic signed [PW_X-1:0]  p_ff0;
	logic signed [PW_X-1:0]  p_ff1;
	logic signed [PW_X-1:0]  p_ff2;
	logic signed [PW_Y-1:0]  p_fb1;
	logic signed [PW_Y-1:0]  p_fb2;
	logic signed [ACC_W-1:0] acc;
	logic signed [ACC_W-1:0] acc_adj;
	logic signed [ACC_W-1:0] quot;

	// Feedforward and feedback products.
	assign p_ff0 = PW_X'(coeffs.ff0) * PW_X'(x0);
	assign p_ff1 = PW_X'(coeffs.ff1) * PW_X'(x1);
	assign p_ff2 = PW_X'(coeffs.ff2) * PW_X'(x2);
	assign p_fb1 = PW_Y'(coeffs.fb1) * PW_Y'(y1);
	assign p_fb2 = PW_Y'(coeffs.fb2) * PW_Y'(y2);

	// Sum of products with the half-LSB rounding bias.
	assign acc = ACC_W'(p_ff0) + ACC_W'(p_ff1) + ACC_W'(p_ff2)
		+ ACC_W'(p_fb1) + ACC_W'(p_fb2) + ROUND_BIAS;

	// Scale down with truncation toward zero: negative sums are biased up
	// by one LSB short of the divisor before the arithmetic shift.
	assign acc_adj = acc[ACC_W-1] ? (acc + TRUNC_ADJ) : acc;
	assign quot    = acc_adj >>> FRACTION_BITS;

	// Clamp to the signed output range.
	always_comb begin
		if (quot > OUT_MAX_A) begin
			y = OUT_MAX_A[OUT_W-1:0];
		end else if (quot < OUT_MIN_A) begin
			y = OUT_MIN_A[OUT_W-1:0];
		end else begin
			y = quot[OUT_W-1:0];
		end
	end

endmodule

@@ rtl/iir_notch_biquad.sv @@
// Top level of the second-order fixed-point IIR notch filter.
// Depends on notch_pkg and instantiates notch_calc.
//
// Second-order IIR filter, 60 Hz notch at 1 kHz after reset. The block takes
// one sample per clock cycle while the output is not stalled and returns one
// filtered sample for each, in order: the sample is captured in an input
// register, where the five products, their sum, the rounding and the 24-bit
// saturation settle in one pass; once the output register is empty or being
// drained, the result loads it and the feedback delay registers together.
// That loop through the multipliers and adder back into the output delay
// register sets the rate of one sample per cycle. A filled, stalled output
// register holds the input register; an empty input register still takes a
// new sample while a result waits. The five weights are written through the
// configuration channel, which is always ready; writes to indexes above four
// are ignored. Weights should only be changed while the filter is idle.
module iir_notch_biquad #(
	parameter int FRACTION_BITS = notch_pkg::FRACTION_BITS_DEF,
	parameter int SAMPLE_WIDTH  = notch_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	// Sample input channel.
	input  logic                                     in_valid,
	output logic                                     in_stall,
	input  logic signed [SAMPLE_WIDTH-1:0]           sample_in,
	// Filtered output channel.
	output logic                                     out_valid,
	input  logic                                     out_stall,
	output logic signed [notch_pkg::OUT_W-1:0]       sample_out,
	// Configuration write channel.
	input  logic                                     cfg_valid,
	output logic                                     cfg_ready,
	input  logic [notch_pkg::INDEX_W-1:0]            cfg_index,
	input  logic signed [notch_pkg::COEFF_W-1:0]     cfg_data
);
	import notch_pkg::*;

	coeff_set_t                     coeff_q;
	logic                           valid_s1;
	logic signed [SAMPLE_WIDTH-1:0] x_s1;
	logic signed [SAMPLE_WIDTH-1:0] x1_q;
	logic signed [SAMPLE_WIDTH-1:0] x2_q;
	logic signed [OUT_W-1:0]        y1_q;
	logic signed [OUT_W-1:0]        y2_q;
	logic                           out_valid_q;
	logic signed [OUT_W-1:0]        out_q;
	logic signed [OUT_W-1:0]        y_next;
	logic                           in_xfer;
	logic                           adv;

	// Handshake control: the input register moves on whenever the output
	// register is empty or being drained this cycle.
	assign adv       = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !adv;
	assign in_xfer   = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign sample_out = out_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coeff_q <= COEFF_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_FF_COEFF_0: coeff_q.ff0 <= cfg_data;
				REG_FF_COEFF_1: coeff_q.ff1 <= cfg_data;
				REG_FF_COEFF_2: coeff_q.ff2 <= cfg_data;
				REG_FB_COEFF_1: coeff_q.fb1 <= cfg_data;
				REG_FB_COEFF_2: coeff_q.fb2 <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			x_s1 <= sample_in;
		end
	end

	// Filter arithmetic for the sample in the input register.
	notch_calc #(
		.FRACTION_BITS(FRACTION_BITS),
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_calc (
		.coeffs(coeff_q),
		.x0    (x_s1),
		.x1    (x1_q),
		.x2    (x2_q),
		.y1    (y1_q),
		.y2    (y2_q),
		.y     (y_next)
	);

	// Delay lines shift only when a sample leaves the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x1_q <= '0;
			x2_q <= '0;
			y1_q <= '0;
			y2_q <= '0;
		end else if (adv) begin
			x1_q <= x_s1;
			x2_q <= x1_q;
			y1_q <= y_next;
			y2_q <= y1_q;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= y_next;
		end
	end

	// The result just loaded is the value fed back.
	a_out_matches_feedback: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> (out_valid && (sample_out == y1_q)))
		else $error("output register and feedback register disagree");

	// The input delay takes the sample that just left the input register.
	a_input_delay_shift: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> (x1_q == $past(x_s1)))
		else $error("input delay line did not shift");

	// Input is held back only while the output register is full.
	a_stall_needs_full_output: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with an empty output register");

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for the iir_notch_biquad filter.
// Depends on notch_pkg and the iir_notch_biquad top level; checks every output against a
// cycle-free model of the same difference equation, with random gaps and stalls.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import notch_pkg::*;

	localparam int SAMPLE_W    = SAMPLE_WIDTH_DEF;
	localparam int FRAC_BITS   = FRACTION_BITS_DEF;
	localparam int REG_COUNT   = int'(REG_FB_COEFF_2) + 1;
	localparam int CYCLE_LIMIT = 200000;
	localparam int TAIL_CYCLES = 8;
	localparam int PHASE_ITEMS = 100;
	localparam int PHASES      = 8;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [OUT_W-1:0]    out_t;
	typedef logic signed [COEFF_W-1:0]  weight_t;

	localparam sample_t SAMPLE_MAX = sample_t'((2 ** (SAMPLE_W - 1)) - 1);
	localparam sample_t SAMPLE_MIN = sample_t'(-(2 ** (SAMPLE_W - 1)));
	localparam longint  OUT_MAX    = (longint'(1) <<< (OUT_W - 1)) - 1;
	localparam longint  OUT_MIN    = -(longint'(1) <<< (OUT_W - 1));
	localparam int      WEIGHT_MAX = (2 ** (COEFF_W - 1)) - 1;
	localparam int      WEIGHT_MIN = -(2 ** (COEFF_W - 1));

	// Weight modes for the random phases.
	typedef enum int {
		MODE_NOTCH,
		MODE_STABLE,
		MODE_WILD,
		MODE_EXTREME
	} weight_mode_t;

	logic                      clk       = 1'b0;
	logic                      arst_n    = 1'b0;
	logic                      in_valid  = 1'b0;
	logic                      in_stall;
	sample_t                   sample_in = '0;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	out_t                      sample_out;
	logic                      cfg_valid = 1'b0;
	logic                      cfg_ready;
	logic [INDEX_W-1:0]        cfg_index = '0;
	weight_t                   cfg_data  = '0;

	bit                        gaps_on     = 1'b1;
	int                        error_count = 0;
	int                        cycle_count = 0;
	out_t                      predicted_samples[$];

	// Model state: weights and the two delay lines.
	weight_t                   weight[REG_COUNT];
	sample_t                   x_one;
	sample_t                   x_two;
	out_t                      y_one;
	out_t                      y_two;

	iir_notch_biquad u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.sample_in (sample_in),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sample_out(sample_out),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// Run limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("** iir_notch_biquad: FAILED **");
			$finish;
		end
	end

	// Random output stalls while gaps are enabled.
	always @(posedge clk) begin
		out_stall <= gaps_on && ($urandom_range(0, 99) < 32);
	end

	// Compare every output transfer against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (predicted_samples.size() == 0) begin
				$error("sample_out: unexpected transfer, expected none, got %0d", sample_out);
				error_count++;
			end else begin
				out_t want;
				want = predicted_samples.pop_front();
				if (sample_out !== want) begin
					$error("sample_out mismatch: expected %0d, got %0d", want, sample_out);
					error_count++;
				end
			end
		end
	end

	// One filter step: weighted sum, bias, division toward zero, 24-bit clamp.
	function automatic out_t notch_predict(sample_t x0);
		longint acc;
		longint quo;
		acc = longint'(weight[REG_FF_COEFF_0]) * longint'(x0)
			+ longint'(weight[REG_FF_COEFF_1]) * longint'(x_one)
			+ longint'(weight[REG_FF_COEFF_2]) * longint'(x_two)
			+ longint'(weight[REG_FB_COEFF_1]) * longint'(y_one)
			+ longint'(weight[REG_FB_COEFF_2]) * longint'(y_two)
			+ (longint'(1) <<< (FRAC_BITS - 1));
		quo = acc / (longint'(1) <<< FRAC_BITS);
		if (quo > OUT_MAX) begin
			quo = OUT_MAX;
		end else if (quo < OUT_MIN) begin
			quo = OUT_MIN;
		end
		x_two = x_one;
		x_one = x0;
		y_two = y_one;
		y_one = out_t'(quo);
		return out_t'(quo);
	endfunction

	// Send one sample, with a random gap in front, and record its prediction.
	task automatic send_sample(input sample_t value);
		while (gaps_on && ($urandom_range(0, 99) < 32)) begin
			in_valid  <= 1'b0;
			sample_in <= sample_t'($urandom);
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		sample_in <= value;
		do @(posedge clk); while (in_stall);
		predicted_samples.push_back(notch_predict(value));
	endtask

	// Stop sending and wait until every predicted output has come back.
	task automatic drain_filter();
		in_valid <= 1'b0;
		@(posedge clk);
		while (predicted_samples.size() != 0) @(posedge clk);
	endtask

	// One register write; cfg_valid stays high for a following write.
	task automatic write_reg(input logic [INDEX_W-1:0] index, input weight_t data);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		if (int'(index) < REG_COUNT) begin
			weight[index] = data;
		end
	endtask

	// Load all five weights while the filter is idle.
	task automatic load_weights(input int ff0, input int ff1, input int ff2,
			input int fb1, input int fb2);
		drain_filter();
		write_reg(REG_FF_COEFF_0, weight_t'(ff0));
		write_reg(REG_FF_COEFF_1, weight_t'(ff1));
		write_reg(REG_FF_COEFF_2, weight_t'(ff2));
		write_reg(REG_FB_COEFF_1, weight_t'(fb1));
		write_reg(REG_FB_COEFF_2, weight_t'(fb2));
		cfg_valid <= 1'b0;
	endtask

	function automatic sample_t random_sample();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 70) begin
			return sample_t'($urandom);
		end else if (pick < 85) begin
			return sample_t'(int'($urandom_range(0, 600)) - 300);
		end
		case ($urandom_range(0, 3))
			0: return SAMPLE_MAX;
			1: return SAMPLE_MIN;
			2: return sample_t'(0);
			default: return sample_t'(-1);
		endcase
	endfunction

	function automatic int random_weight(input int lo, input int hi);
		return lo + int'($urandom_range(0, hi - lo));
	endfunction

	function automatic int extreme_weight();
		return $urandom_range(0, 1) ? WEIGHT_MAX : WEIGHT_MIN;
	endfunction

	// Reset weights: impulse, sign change and small values through the notch.
	task automatic test_reset_weights();
		send_sample(SAMPLE_MAX);
		send_sample(sample_t'(0));
		send_sample(sample_t'(0));
		send_sample(SAMPLE_MIN);
		send_sample(sample_t'(-1));
		send_sample(sample_t'(1));
	endtask

	// A weight of 1/256 on the current sample: the bias is added and the quotient
	// truncates toward zero, so small negative sums round up to zero.
	task automatic test_rounding_toward_zero();
		load_weights(1, 0, 0, 0, 0);
		send_sample(sample_t'(127));
		send_sample(sample_t'(128));
		send_sample(sample_t'(-128));
		send_sample(sample_t'(-129));
		send_sample(sample_t'(-384));
		send_sample(sample_t'(-385));
		send_sample(SAMPLE_MIN);
		send_sample(SAMPLE_MAX);
	endtask

	// Maximum weights drive the output into the upper clamp, then negative
	// weights throw the clamped feedback against the lower clamp.
	task automatic test_output_clamp();
		load_weights(WEIGHT_MAX, WEIGHT_MAX, WEIGHT_MAX, WEIGHT_MAX, WEIGHT_MAX);
		repeat (4) send_sample(SAMPLE_MAX);
		load_weights(WEIGHT_MIN, WEIGHT_MIN, WEIGHT_MIN, WEIGHT_MIN, WEIGHT_MIN);
		repeat (4) send_sample(SAMPLE_MAX);
	endtask

	// Writes above the last register index must leave the weights alone.
	task automatic test_ignored_indexes();
		drain_filter();
		for (int idx = REG_COUNT; idx < (2 ** INDEX_W); idx++) begin
			write_reg(idx[INDEX_W-1:0], weight_t'($urandom));
		end
		cfg_valid <= 1'b0;
		send_sample(random_sample());
		send_sample(random_sample());
	endtask

	// Random samples over several weight settings; one phase runs without gaps.
	task automatic test_random_traffic();
		weight_mode_t mode;
		int           fb2;
		int           lim;
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0:       mode = MODE_NOTCH;
				3, 6:    mode = MODE_WILD;
				4:       mode = MODE_EXTREME;
				default: mode = MODE_STABLE;
			endcase
			case (mode)
				MODE_NOTCH: begin
					load_weights(int'(COEFF_RESET.ff0), int'(COEFF_RESET.ff1),
						int'(COEFF_RESET.ff2), int'(COEFF_RESET.fb1),
						int'(COEFF_RESET.fb2));
				end
				MODE_STABLE: begin
					// Poles kept inside the unit circle.
					fb2 = random_weight(-200, 200);
					lim = 250 - fb2;
					load_weights(random_weight(-512, 511), random_weight(-512, 511),
						random_weight(-512, 511), random_weight(-lim, lim), fb2);
				end
				MODE_WILD: begin
					load_weights(random_weight(WEIGHT_MIN, WEIGHT_MAX),
						random_weight(WEIGHT_MIN, WEIGHT_MAX),
						random_weight(WEIGHT_MIN, WEIGHT_MAX),
						random_weight(WEIGHT_MIN, WEIGHT_MAX),
						random_weight(WEIGHT_MIN, WEIGHT_MAX));
				end
				default: begin
					load_weights(extreme_weight(), extreme_weight(), extreme_weight(),
						extreme_weight(), extreme_weight());
				end
			endcase
			gaps_on = (phase != 1);
			repeat (PHASE_ITEMS) send_sample(random_sample());
		end
		gaps_on = 1'b1;
	endtask

	initial begin
		weight[REG_FF_COEFF_0] = COEFF_RESET.ff0;
		weight[REG_FF_COEFF_1] = COEFF_RESET.ff1;
		weight[REG_FF_COEFF_2] = COEFF_RESET.ff2;
		weight[REG_FB_COEFF_1] = COEFF_RESET.fb1;
		weight[REG_FB_COEFF_2] = COEFF_RESET.fb2;
		x_one = '0;
		x_two = '0;
		y_one = '0;
		y_two = '0;

		// Asynchronous reset, released away from the rising edge.
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_weights();
		test_rounding_toward_zero();
		test_output_clamp();
		test_ignored_indexes();
		test_random_traffic();

		drain_filter();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (predicted_samples.size() != 0) begin
			$error("sample_out: %0d expected transfers never arrived", predicted_samples.size());
			error_count++;
		end
		if (error_count == 0) begin
			$display("** iir_notch_biquad: PASSED **");
		end else begin
			$display("** iir_notch_biquad: FAILED **");
		end
		$finish;
	end

endmodule

@@ files.f @@
rtl/notch_pkg.sv
rtl/notch_calc.sv
rtl/iir_notch_biquad.sv
dv/tb_top.sv
